@@ hw/rtl/lap_pkg.sv @@
// Shared types, codes, constants and helper functions of the Lorenz attractor plotter.
package lap_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 22;
	localparam int STAT_W    = 3;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int CFG_IDX_W = 3;
	localparam int SAT_W     = 66;

	typedef logic [CMD_W-1:0]          cmd_t;
	typedef logic [STAT_W-1:0]         res_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [PIX_W-1:0]          pix_t;
	typedef logic [2:0]                mop_t;
	typedef logic signed [SAT_W-1:0]   wide_t;

	// Input item commands
	localparam cmd_t CMD_STEP    = 2'd0;
	localparam cmd_t CMD_READ    = 2'd1;
	localparam cmd_t CMD_RESTART = 2'd2;

	// Result status codes
	localparam res_t RES_PLOTTED   = 3'd0;
	localparam res_t RES_OFF_IMAGE = 3'd1;
	localparam res_t RES_EXHAUSTED = 3'd2;
	localparam res_t RES_READ_DATA = 3'd3;
	localparam res_t RES_RESTARTED = 3'd4;

	// Configuration register indexes
	localparam cfg_idx_t REG_SIGMA       = 3'd0;
	localparam cfg_idx_t REG_RHO         = 3'd1;
	localparam cfg_idx_t REG_BETA        = 3'd2;
	localparam cfg_idx_t REG_TIME_STEP   = 3'd3;
	localparam cfg_idx_t REG_POINT_COUNT = 3'd4;

	// Configuration reset values
	localparam logic signed [31:0] SIGMA_RST     = 32'sd167772160;
	localparam logic signed [31:0] RHO_RST       = 32'sd469762048;
	localparam logic signed [31:0] BETA_RST      = 32'sd44739243;
	localparam logic signed [31:0] TIME_STEP_RST = 32'sd83886;
	localparam logic [31:0]        POINT_CNT_RST = 32'd1000000;

	// Multiplier operations, numbered in issue order of one Euler step
	localparam mop_t MOP_KDT   = 3'd0;  // sigma * dt
	localparam mop_t MOP_RX    = 3'd1;  // rho * x
	localparam mop_t MOP_ZX    = 3'd2;  // z * x
	localparam mop_t MOP_XY    = 3'd3;  // x * y
	localparam mop_t MOP_BZ    = 3'd4;  // beta * z
	localparam mop_t MOP_KDX   = 3'd5;  // (sigma*dt) * (y - x)
	localparam mop_t MOP_DTIY  = 3'd6;  // dt * y increment
	localparam mop_t MOP_DTIZ  = 3'd7;  // dt * z increment
	localparam int   MOP_COUNT = 8;

	// Screen mapping
	localparam int COL_BIAS  = 980;
	localparam int COL_SCALE = 800;
	localparam int ROW_BIAS  = 724;
	localparam int ROW_SCALE = 200;

	// Per-plot color increments: (K + c*256) >> 8 is c + (K >> 8)
	localparam logic [CH_W-1:0] RED_INC   = CH_W'((5 * 150) >> 8);
	localparam logic [CH_W-1:0] GREEN_INC = CH_W'((7 * 150) >> 8);
	localparam logic [CH_W-1:0] BLUE_INC  = CH_W'((10 * 150) >> 8);

	localparam wide_t MAX32 = wide_t'(64'sd2147483647);
	localparam wide_t MIN32 = -MAX32 - wide_t'(1);

	// Controller to datapath commands
	typedef struct packed {
		logic clr_en;
		logic accept;
		logic restart;
		logic mul_en;
		mop_t mul_op;
		logic addr1_en;
		logic addr2_en;
		logic rd_en;
		logic rd_step;
		logic pix_wr;
		logic count_inc;
		logic res_load;
		res_t res_code;
	} lap_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic exhausted;
		logic off_image;
	} lap_stat_t;

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input wide_t v);
		logic signed [31:0] r;
		if (v > MAX32) begin
			r = 32'sh7FFFFFFF;
		end else if (v < MIN32) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Add to a color channel, saturating at full scale
	function automatic logic [CH_W-1:0] chan_add(input logic [CH_W-1:0] c,
		input logic [CH_W-1:0] inc);
		logic [CH_W:0] s;
		s = {1'b0, c} + {1'b0, inc};
		return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
	endfunction

endpackage

@@ hw/rtl/lap_fstore.sv @@
// Frame store memory: one write port, one read port with registered read data.
module lap_fstore import lap_pkg::*; #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pix_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output pix_t          rdata
);

	pix_t mem_q [DEPTH];
	pix_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lap_dp.sv @@
// Datapath: trajectory state, shared multiplier, pixel address, frame store and result register.
module lap_dp import lap_pkg::*; #(
	parameter int ROW_SHIFT    = 11,
	parameter int FRAME_PIXELS = 3145728,
	parameter int FRAC_BITS    = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lap_cmd_t                 ctl,
	output lap_stat_t                stat,
	input  logic [IDX_W-1:0]         read_index,
	input  logic                     cfg_we,
	input  cfg_idx_t                 cfg_index,
	input  logic [31:0]              cfg_data,
	output res_t                     status,
	output logic [IDX_W-1:0]         pixel_index,
	output logic [CH_W-1:0]          red,
	output logic [CH_W-1:0]          green,
	output logic [CH_W-1:0]          blue,
	output logic signed [31:0]       new_x,
	output logic signed [31:0]       new_y,
	output logic signed [31:0]       new_z
);

	localparam int AW    = $clog2(FRAME_PIXELS);
	localparam int PW    = 64 - FRAC_BITS;
	localparam int AD_W  = 44;
	localparam int RD_CW = IDX_W + 4;
	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam logic signed [31:0]     TENTH_Q = 32'((ONE_Q + 5) / 10);
	localparam logic signed [AD_W-1:0] RND     = AD_W'(ONE_Q - 1);
	localparam logic signed [AD_W-1:0] FP_S    = AD_W'(FRAME_PIXELS);
	localparam logic [RD_CW-1:0]       FP_U    = RD_CW'(FRAME_PIXELS);
	localparam logic [AW-1:0]          CLR_END = AW'(FRAME_PIXELS - 1);

	// Configuration
	logic signed [31:0] sigma_q, rho_q, beta_q, dt_q;
	logic [31:0]        pcount_q;

	// Trajectory
	logic signed [31:0] x_q, y_q, z_q;
	logic [31:0]        steps_q;

	// Step intermediates
	logic signed [31:0]   k_q, dx_q, iy_q, iz_q;
	logic signed [PW-1:0] rx_q, xy_q;

	// Multiplier
	logic signed [31:0]   mul_a, mul_b;
	logic signed [63:0]   prod_s1;
	mop_t                 mop_s1;
	logic                 mvld_s1;
	logic signed [PW-1:0] prod_r;

	// Saturated sums
	logic signed [31:0] s_k, s_dx, s_iy, s_iz, s_nx, s_ny, s_nz;

	// Pixel address
	logic signed [AD_W-1:0] xm, ym, xb, yb, col_n, row_n, pp_n;
	logic signed [AD_W-1:0] col_s1, row_s1, pp_s2;
	logic                   off_s2;

	// Frame store access
	logic [AW-1:0] clr_addr_q;
	logic          fs_we, fs_re;
	logic [AW-1:0] fs_waddr, fs_raddr;
	pix_t          fs_wdata, fs_rdata, pix_n, pix_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic          rd_in_range;

	// Result register
	res_t               res_status_q;
	logic [IDX_W-1:0]   res_index_q;
	logic [CH_W-1:0]    res_red_q, res_green_q, res_blue_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= SIGMA_RST;
			rho_q    <= RHO_RST;
			beta_q   <= BETA_RST;
			dt_q     <= TIME_STEP_RST;
			pcount_q <= POINT_CNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIGMA:       sigma_q  <= cfg_data;
				REG_RHO:         rho_q    <= cfg_data;
				REG_BETA:        beta_q   <= cfg_data;
				REG_TIME_STEP:   dt_q     <= cfg_data;
				REG_POINT_COUNT: pcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select multiplier operands
	always_comb begin
		case (ctl.mul_op)
			MOP_KDT: begin
				mul_a = sigma_q;
				mul_b = dt_q;
			end
			MOP_RX: begin
				mul_a = rho_q;
				mul_b = x_q;
			end
			MOP_ZX: begin
				mul_a = z_q;
				mul_b = x_q;
			end
			MOP_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			MOP_BZ: begin
				mul_a = beta_q;
				mul_b = z_q;
			end
			MOP_KDX: begin
				mul_a = k_q;
				mul_b = dx_q;
			end
			MOP_DTIY: begin
				mul_a = dt_q;
				mul_b = iy_q;
			end
			MOP_DTIZ: begin
				mul_a = dt_q;
				mul_b = iz_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Multiply and register the full product
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		mop_s1  <= ctl.mul_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_s1 <= 1'b0;
		end else begin
			mvld_s1 <= ctl.mul_en;
		end
	end

	// Scale back with a floor shift
	assign prod_r = PW'(prod_s1 >>> FRAC_BITS);

	assign s_k  = sat32(wide_t'(prod_r));
	assign s_dx = sat32(wide_t'(y_q) - wide_t'(x_q));
	assign s_iy = sat32(wide_t'(rx_q) - wide_t'(y_q) - wide_t'(prod_r));
	assign s_iz = sat32(wide_t'(xy_q) - wide_t'(prod_r));
	assign s_nx = sat32(wide_t'(x_q) + wide_t'(prod_r));
	assign s_ny = sat32(wide_t'(y_q) + wide_t'(prod_r));
	assign s_nz = sat32(wide_t'(z_q) + wide_t'(prod_r));

	// Collect products into the step intermediates
	always_ff @(posedge clk) begin
		if (mvld_s1) begin
			case (mop_s1)
				MOP_KDT: begin
					k_q  <= s_k;
					dx_q <= s_dx;
				end
				MOP_RX:  rx_q <= prod_r;
				MOP_ZX:  iy_q <= s_iy;
				MOP_XY:  xy_q <= prod_r;
				MOP_BZ:  iz_q <= s_iz;
				default: ;
			endcase
		end
	end

	// Update the point and the step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= TENTH_Q;
			y_q     <= TENTH_Q;
			z_q     <= TENTH_Q;
			steps_q <= '0;
		end else if (ctl.restart) begin
			x_q     <= TENTH_Q;
			y_q     <= TENTH_Q;
			z_q     <= TENTH_Q;
			steps_q <= '0;
		end else begin
			if (mvld_s1) begin
				case (mop_s1)
					MOP_KDX:  x_q <= s_nx;
					MOP_DTIY: y_q <= s_ny;
					MOP_DTIZ: z_q <= s_nz;
					default: ;
				endcase
			end
			if (ctl.count_inc) begin
				steps_q <= steps_q + 32'd1;
			end
		end
	end

	// Scale the point to screen coordinates, truncating toward zero
	always_comb begin
		xm = AD_W'(x_q) * AD_W'(COL_SCALE);
		ym = AD_W'(y_q) * AD_W'(ROW_SCALE);
		xb = xm;
		yb = ym;
		if (xm[AD_W-1]) begin
			xb = xm + RND;
		end
		if (ym[AD_W-1]) begin
			yb = ym + RND;
		end
		col_n = AD_W'(COL_BIAS) + (xb >>> FRAC_BITS);
		row_n = AD_W'(ROW_BIAS) + (yb >>> FRAC_BITS);
	end

	assign pp_n = col_s1 + (row_s1 <<< ROW_SHIFT);

	// Register column/row, then the linear index and its bounds check
	always_ff @(posedge clk) begin
		if (ctl.addr1_en) begin
			col_s1 <= col_n;
			row_s1 <= row_n;
		end
		if (ctl.addr2_en) begin
			pp_s2  <= pp_n;
			off_s2 <= pp_n[AD_W-1] || (pp_n >= FP_S);
		end
	end

	// Hold the read index of an accepted item
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_idx_q <= read_index;
		end
	end

	assign rd_in_range = RD_CW'(rd_idx_q) < FP_U;

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (ctl.clr_en) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Brighten the pixel read from the store
	assign pix_n = {chan_add(fs_rdata[2*CH_W +: CH_W], RED_INC),
		chan_add(fs_rdata[CH_W +: CH_W], GREEN_INC),
		chan_add(fs_rdata[0 +: CH_W], BLUE_INC)};

	always_ff @(posedge clk) begin
		if (ctl.pix_wr) begin
			pix_q <= pix_n;
		end
	end

	assign fs_we    = ctl.clr_en || (ctl.pix_wr && !off_s2);
	assign fs_waddr = ctl.clr_en ? clr_addr_q : pp_s2[AW-1:0];
	assign fs_wdata = ctl.clr_en ? '0 : pix_n;
	assign fs_re    = ctl.rd_en && (ctl.rd_step ? !off_s2 : rd_in_range);
	assign fs_raddr = ctl.rd_step ? pp_s2[AW-1:0] : AW'(rd_idx_q);

	lap_fstore #(
		.DEPTH (FRAME_PIXELS)
	) u_fstore (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.re    (fs_re),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	// Load the result register
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_status_q <= ctl.res_code;
			res_index_q  <= '0;
			res_red_q    <= '0;
			res_green_q  <= '0;
			res_blue_q   <= '0;
			res_x_q      <= x_q;
			res_y_q      <= y_q;
			res_z_q      <= z_q;
			case (ctl.res_code)
				RES_PLOTTED: begin
					res_index_q <= pp_s2[IDX_W-1:0];
					res_red_q   <= pix_q[2*CH_W +: CH_W];
					res_green_q <= pix_q[CH_W +: CH_W];
					res_blue_q  <= pix_q[0 +: CH_W];
				end
				RES_READ_DATA: begin
					res_index_q <= rd_idx_q;
					if (rd_in_range) begin
						res_red_q   <= fs_rdata[2*CH_W +: CH_W];
						res_green_q <= fs_rdata[CH_W +: CH_W];
						res_blue_q  <= fs_rdata[0 +: CH_W];
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.clr_last  = clr_addr_q == CLR_END;
	assign stat.exhausted = steps_q >= pcount_q;
	assign stat.off_image = off_s2;

	assign status      = res_status_q;
	assign pixel_index = res_index_q;
	assign red         = res_red_q;
	assign green       = res_green_q;
	assign blue        = res_blue_q;
	assign new_x       = res_x_q;
	assign new_y       = res_y_q;
	assign new_z       = res_z_q;

endmodule

@@ hw/rtl/lap_ctrl.sv @@
// Controller: clearing pass, command dispatch, step sequencing and output handshake.
module lap_ctrl import lap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_stall,
	input  lap_stat_t stat,
	output lap_cmd_t  dp_cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	localparam logic [3:0] PH_ADDR1 = 4'd0;
	localparam logic [3:0] PH_ADDR2 = 4'd1;
	localparam logic [3:0] PH_RD    = 4'd2;
	localparam logic [3:0] PH_WR    = 4'd3;
	localparam logic [3:0] PH_LAST  = 4'(MOP_COUNT);

	logic [2:0] state_q;
	logic [3:0] ph_q;
	res_t       res_code_q;
	logic       out_valid_q;
	logic       accept;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;

	// Decode commands for the datapath
	always_comb begin
		dp_cmd           = '0;
		dp_cmd.clr_en    = state_q == S_CLEAR;
		dp_cmd.accept    = accept;
		dp_cmd.restart   = accept && (cmd == CMD_RESTART);
		dp_cmd.res_code  = res_code_q;
		// Operations are issued one per phase in their numbered order
		dp_cmd.mul_op    = mop_t'(ph_q[2:0]);
		case (state_q)
			S_STEP: begin
				dp_cmd.mul_en    = ph_q != PH_LAST;
				dp_cmd.addr1_en  = ph_q == PH_ADDR1;
				dp_cmd.addr2_en  = ph_q == PH_ADDR2;
				dp_cmd.rd_en     = ph_q == PH_RD;
				dp_cmd.rd_step   = 1'b1;
				dp_cmd.pix_wr    = ph_q == PH_WR;
				dp_cmd.count_inc = ph_q == PH_LAST;
			end
			S_READ: begin
				dp_cmd.rd_en = 1'b1;
			end
			S_OUT: begin
				dp_cmd.res_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	// Advance the state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ph_q       <= '0;
			res_code_q <= RES_PLOTTED;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_STEP: begin
								if (stat.exhausted) begin
									res_code_q <= RES_EXHAUSTED;
									state_q    <= S_OUT;
								end else begin
									ph_q    <= '0;
									state_q <= S_STEP;
								end
							end
							CMD_READ: begin
								res_code_q <= RES_READ_DATA;
								state_q    <= S_READ;
							end
							CMD_RESTART: begin
								res_code_q <= RES_RESTARTED;
								state_q    <= S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_STEP: begin
					if (ph_q == PH_LAST) begin
						res_code_q <= stat.off_image ? RES_OFF_IMAGE : RES_PLOTTED;
						state_q    <= S_OUT;
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				S_READ: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (dp_cmd.res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (ph_q <= PH_LAST))
		else $error("step phase past last");

	a_step_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && ph_q == PH_LAST) |=> (state_q == S_OUT))
		else $error("step did not finish into output");

	a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_STEP || cmd == CMD_READ || cmd == CMD_RESTART))
		|=> (state_q != S_IDLE))
		else $error("accepted item left controller idle");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(dp_cmd.res_load))
		else $error("output valid without result load");

endmodule

@@ hw/rtl/lorenz_attractor_plotter.sv @@
// Top level of the Lorenz attractor plotter: controller, datapath and port wiring.
//
// Input channel (in_valid/in_stall, cmd, read_index) takes one item per command:
// step-and-plot, read pixel or restart. An item is taken when in_valid is high and
// in_stall is low. Output channel (out_valid/out_stall) returns one result item per
// command; unused command codes are dropped without a result. Configuration writes
// (cfg_valid/cfg_ready, cfg_index, cfg_data) set sigma, rho, beta, time step and point
// count; cfg_ready is always high and writes are meant for idle periods only.
// Items are handled one at a time: the controller returns to idle before taking the
// next, so no new item is taken until the result of the last one is loaded. A step
// runs the eight multiplications of one Euler update through a single shared 32x32
// multiplier, one issued per cycle, then takes the last product and loads the result.
// The result sits in an output register, so the next item is taken while it waits;
// under a stalled receiver the result holds and the following item waits at the
// output register before its result is loaded.
// After reset the frame store is cleared one pixel per cycle, covering all FRAME_PIXELS
// pixels, and in_stall stays high until the pass ends. The point restarts at 0.1.
module lorenz_attractor_plotter import lap_pkg::*; #(
	parameter int ROW_SHIFT    = 11,
	parameter int FRAME_PIXELS = 3145728,
	parameter int FRAC_BITS    = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [IDX_W-1:0]   read_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [IDX_W-1:0]   pixel_index,
	output logic [CH_W-1:0]    red,
	output logic [CH_W-1:0]    green,
	output logic [CH_W-1:0]    blue,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  cfg_idx_t           cfg_index,
	input  logic [31:0]        cfg_data
);

	lap_cmd_t  dp_cmd;
	lap_stat_t dp_stat;
	logic      cfg_we;

	// Configuration is always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	lap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	lap_dp #(
		.ROW_SHIFT    (ROW_SHIFT),
		.FRAME_PIXELS (FRAME_PIXELS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (dp_cmd),
		.stat        (dp_stat),
		.read_index  (read_index),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.status      (status),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.new_x       (new_x),
		.new_y       (new_y),
		.new_z       (new_z)
	);

endmodule
